// ===== sv/assert_macros.svh =====
// Assertion macros shared by the fraction reduce modules.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

// ===== sv/fr_pkg.sv =====
// Package for the fraction reduce block: engine state type.
// Depends on nothing.
package fr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } fr_state_t;

endpackage

// ===== sv/fr_front.sv =====
// Front part: accepts items, takes magnitudes and signs, flags zero parts.
// Depends on nothing but its ports; writes one entry into the queue.
module fr_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] numerator,
  input  logic [DATA_WIDTH-1:0] denominator,
  output logic                  q_valid,
  input  logic                  q_take,
  output logic [DATA_WIDTH-1:0] q_an,
  output logic [DATA_WIDTH-1:0] q_ad,
  output logic                  q_neg,
  output logic                  q_zero
);
  logic                  full;
  logic [DATA_WIDTH-1:0] an, ad;
  logic                  neg, zero;
  logic                  accept;

  // The stage takes a new item whenever it is empty or is being drained.
  assign in_stall = full && !q_take;
  assign accept   = in_valid && !in_stall;

  // Registered classification.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (q_take) begin
      full <= 1'b0;
    end
    if (accept) begin
      an   <= numerator[DATA_WIDTH-1] ? (~numerator + 1'b1) : numerator;
      ad   <= denominator[DATA_WIDTH-1] ? (~denominator + 1'b1) : denominator;
      neg  <= numerator[DATA_WIDTH-1] ^ denominator[DATA_WIDTH-1];
      zero <= (numerator == '0) || (denominator == '0);
    end
  end

  assign q_valid = full;
  assign q_an    = an;
  assign q_ad    = ad;
  assign q_neg   = neg;
  assign q_zero  = zero;
endmodule

// ===== sv/fr_queue.sv =====
// Two-entry queue between the front and back parts.
// Depends on nothing but its ports.
module fr_queue #(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_take,
  output logic [W-1:0] rd_data
);
  logic [W-1:0] mem [2];
  logic         wp, rp;
  logic [1:0]   count;
  logic         wr, rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_take && rd_valid;
  assign rd_data  = mem[rp];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem[wp] <= wr_data;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overflow, count == 2'd2, !wr)
  `ASSERT_ALWAYS(a_count_range, count != 2'd3)
endmodule

// ===== sv/fr_back.sv =====
// Back part: Euclid GCD and two exact divisions on one restoring divider.
// Depends on fr_pkg for the state type.
module fr_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_take,
  input  logic [DATA_WIDTH-1:0] q_an,
  input  logic [DATA_WIDTH-1:0] q_ad,
  input  logic                  q_neg,
  input  logic                  q_zero,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] rnum,
  output logic [DATA_WIDTH-2:0] rden
);
  import fr_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);

  fr_state_t             state, state_next;
  logic [DATA_WIDTH-1:0] an, ad, x, y, g;
  logic                  neg;
  // Divider: dividend shifts out, remainder builds up, quotient in dvd.
  logic [DATA_WIDTH-1:0] dvd, dvs, rem;
  logic [CW-1:0]         cnt;
  logic                  dbusy;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] rem_sh;
  logic                  dlast;
  logic [DATA_WIDTH-1:0] qnum;

  assign rem_sh = {rem[DATA_WIDTH-2:0], dvd[DATA_WIDTH-1]};
  assign trial  = {rem[DATA_WIDTH-1], rem_sh} - {1'b0, dvs};
  assign dlast  = dbusy && (cnt == CW'(DATA_WIDTH - 1));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = q_zero ? ST_DONE : ST_GCD;
      ST_GCD:  if (!dbusy && y == '0) state_next = ST_DIVN;
      ST_DIVN: if (dlast) state_next = ST_DIVD;
      ST_DIVD: if (dlast) state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_take    = (state == ST_IDLE) && q_valid;
    out_valid = (state == ST_DONE);
  end

  // Datapath: one remainder bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dbusy <= 1'b0;
    end else begin
      state <= state_next;
      if (q_take) begin
        an  <= q_an;
        ad  <= q_ad;
        neg <= q_neg;
        x   <= q_an;
        y   <= q_ad;
        // A fresh item starts with no remainder pending.
        cnt <= '0;
        if (q_zero) begin
          rnum <= '0;
          rden <= {{(DATA_WIDTH-2){1'b0}}, 1'b1};
        end
      end
      if (dbusy) begin
        cnt <= cnt + 1'b1;
        if (!trial[DATA_WIDTH]) begin
          rem <= trial[DATA_WIDTH-1:0];
          dvd <= {dvd[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dvd <= {dvd[DATA_WIDTH-2:0], 1'b0};
        end
        if (dlast) dbusy <= 1'b0;
      end
      // Euclid step: remainder becomes new y.
      if (state == ST_GCD && !dbusy && y != '0) begin
        if (cnt == CW'(DATA_WIDTH)) begin
          x   <= y;
          y   <= rem;
          cnt <= '0;
        end else begin
          dvd <= x; dvs <= y; rem <= '0; cnt <= '0; dbusy <= 1'b1;
        end
      end
      if (state == ST_GCD && dlast) cnt <= CW'(DATA_WIDTH);
      if (state == ST_GCD && !dbusy && y == '0) begin
        g <= x;
        dvd <= an; dvs <= x; rem <= '0; cnt <= '0; dbusy <= 1'b1;
      end
      if (state == ST_DIVN && dlast) begin
        rnum <= neg ? (~qnum + 1'b1) : qnum;
        dvd <= ad; dvs <= g; rem <= '0; cnt <= '0; dbusy <= 1'b1;
      end
      if (state == ST_DIVD && dlast) begin
        rden <= qnum[DATA_WIDTH-2:0];
      end
    end
  end

  assign qnum = {dvd[DATA_WIDTH-2:0], !trial[DATA_WIDTH]};

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_busy_only_work, dbusy,
               state == ST_GCD || state == ST_DIVN || state == ST_DIVD)
  `ASSERT_IMPL(a_take_idle, q_take, state == ST_IDLE)
endmodule

// ===== sv/fraction_reduce.sv =====
// Fraction reduce top level: reduces a signed fraction to lowest terms.
// Depends on fr_front, fr_queue and fr_back.
// Each Euclid remainder step and each final division runs one bit per cycle
// on a single shared restoring divider in the back part; each Euclid step
// also starts the divider and then moves the remainder into y. A zero part
// returns 0/1 without using the divider. The front part and a two-entry
// queue keep accepting items while the back part works, until they fill.
module fraction_reduce #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] numerator,
  input  logic [DATA_WIDTH-1:0] denominator,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] reduced_numerator,
  output logic [DATA_WIDTH-2:0] reduced_denominator
);
  localparam int QW = 2 * DATA_WIDTH + 2;

  logic                  f_valid, f_take, b_valid, b_take;
  logic [DATA_WIDTH-1:0] f_an, f_ad;
  logic                  f_neg, f_zero;
  logic [QW-1:0]         b_data;

  fr_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .numerator, .denominator,
    .q_valid(f_valid), .q_take(f_take), .q_an(f_an), .q_ad(f_ad),
    .q_neg(f_neg), .q_zero(f_zero)
  );

  fr_queue #(.W(QW)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_take),
    .wr_data({f_an, f_ad, f_neg, f_zero}),
    .rd_valid(b_valid), .rd_take(b_take), .rd_data(b_data)
  );

  fr_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst, .q_valid(b_valid), .q_take(b_take),
    .q_an(b_data[QW-1 -: DATA_WIDTH]), .q_ad(b_data[DATA_WIDTH+1 -: DATA_WIDTH]),
    .q_neg(b_data[1]), .q_zero(b_data[0]),
    .out_valid, .out_stall,
    .rnum(reduced_numerator), .rden(reduced_denominator)
  );
endmodule

// ===== sim/tb.sv =====
// Testbench for fraction_reduce: drives signed fractions and checks each
// reduced result against a predictor built on Euclid's remainder method.
// Depends on the fraction_reduce RTL only.
module tb;

  localparam int W = 32;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
  } frac_item_t;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-2:0] den;
  } frac_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [W-1:0] numerator = '0;
  logic [W-1:0] denominator = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [W-1:0] reduced_numerator;
  logic [W-2:0] reduced_denominator;

  frac_item_t pending_items[$];
  frac_result_t expected_fracs[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit in_fire = 1'b0;

  fraction_reduce #(.DATA_WIDTH(W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .numerator(numerator), .denominator(denominator),
    .out_valid(out_valid), .out_stall(out_stall),
    .reduced_numerator(reduced_numerator),
    .reduced_denominator(reduced_denominator)
  );

  always #2 clk = ~clk;

  // Magnitude of a two's-complement value; the most negative value maps to 2^(W-1).
  function automatic logic [W:0] abs_val(input logic [W-1:0] v);
    logic [W:0] m;
    m = v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    return m;
  endfunction

  // Fraction in lowest terms with the sign carried by the numerator.
  function automatic frac_result_t reduce_frac(input frac_item_t it);
    frac_result_t r;
    logic [W:0] an, ad, x, y, t, rn, rd;
    an = abs_val(it.num);
    ad = abs_val(it.den);
    if (an == 0 || ad == 0) begin
      r.num = '0;
      r.den = (W-1)'(1);
      return r;
    end
    x = an;
    y = ad;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    rn = an / x;
    rd = ad / x;
    if (it.num[W-1] != it.den[W-1]) rn = ~rn + 1'b1;
    r.num = rn[W-1:0];
    r.den = rd[W-2:0];
    return r;
  endfunction

  function automatic logic [W-1:0] rand_word(input int mode);
    logic [W-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $urandom_range(0, 40) - 20;
      2: v = ($urandom_range(1, 5000) * $urandom_range(1, 1000));
      default: v = $urandom_range(0, 255) << $urandom_range(0, 23);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Input handshake as seen at the rising edge, for the driver.
  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall;
  end

  // Driver: presents queued items, holding each until accepted.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) void'(pending_items.pop_front());
      if ((!in_valid || in_fire) && pending_items.size() > 0 &&
          $urandom_range(1, 100) > send_idle_pct) begin
        in_valid <= 1'b1;
        numerator <= pending_items[0].num;
        denominator <= pending_items[0].den;
      end else if (!in_valid || in_fire) begin
        in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk) begin
    frac_result_t exp_r;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        expected_fracs.push_back(reduce_frac('{num: numerator, den: denominator}));
      end
      if (out_valid && !out_stall) begin
        if (expected_fracs.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result %0d/%0d",
            $signed(reduced_numerator), reduced_denominator);
        end else begin
          exp_r = expected_fracs.pop_front();
          if (exp_r.num !== reduced_numerator || exp_r.den !== reduced_denominator) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected %0d/%0d got %0d/%0d",
                $signed(exp_r.num), exp_r.den,
                $signed(reduced_numerator), reduced_denominator);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic add_frac(input logic [W-1:0] n, input logic [W-1:0] d);
    pending_items.push_back('{num: n, den: d});
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_fracs.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int phase_idle[4] = '{0, 87, 0, 28};
    int phase_stall[4] = '{0, 0, 87, 28};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero parts, sign combinations, extremes, most negative value.
    add_frac(0, 0);
    add_frac(0, 7);
    add_frac(5, 0);
    add_frac(-3, 0);
    add_frac(6, 4);
    add_frac(-6, 4);
    add_frac(6, -4);
    add_frac(-6, -4);
    add_frac(32'h7fffffff, 32'h7fffffff);
    add_frac(32'h80000001, 32'h7fffffff);
    add_frac(32'h7fffffff, 1);
    add_frac(1, 32'h80000001);
    add_frac(32'h80000000, 2);
    add_frac(1, 32'h80000000);
    add_frac(32'h80000000, 32'hffffffff);
    add_frac(32'h80000000, 32'h80000000);
    add_frac(32'hffffffff, 32'hffffffff);
    add_frac(1836311903, 1134903170);
    add_frac(32'hffffffff, 32'h7ffffffe);
    add_frac(32'h55555555, 32'haaaaaaab);
    drain();

    // Random phases under different idle and stall patterns.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 240; i++) begin
        logic [W-1:0] n, d;
        logic [W-1:0] g;
        if ($urandom_range(0, 3) == 0) begin
          g = $urandom_range(1, 3000);
          n = g * $urandom_range(0, 50000);
          d = g * $urandom_range(1, 50000);
          if ($urandom_range(0, 1)) n = -n;
          if ($urandom_range(0, 1)) d = -d;
        end else begin
          n = rand_word($urandom_range(0, 3));
          d = rand_word($urandom_range(0, 3));
        end
        add_frac(n, d);
      end
      drain();
    end

    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && expected_fracs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fr_pkg.sv
sv/fr_front.sv
sv/fr_queue.sv
sv/fr_back.sv
sv/fraction_reduce.sv
sim/tb.sv
